>>> src/smf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window median filter.
package smf_pkg;

  // Width of the reported fill count field.
  localparam int unsigned COUNT_BITS = 5;

  // Sequencer states: waiting for a sample, ranking the window, handing off the median.
  typedef enum logic [1:0] {
    SMF_IDLE,
    SMF_RANK,
    SMF_PICK
  } smf_state_e;

  // Control strobes from the sequencer to the cell row and the output register.
  typedef struct packed {
    logic load;     // a sample is accepted this cycle
    logic rank_en;  // probes advance one cell and ranks accumulate
    logic pick;     // the median is written into the output register
  } smf_ctrl_t;

endpackage

>>> src/smf_cell.sv
`timescale 1ns / 1ps
// One window cell: holds a sample, passes a circulating probe and counts its rank.
module smf_cell #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned IDX_W       = 5,
  parameter int unsigned CNT_W       = 5,
  parameter int unsigned CELL_IDX    = 0
) (
  input  logic                   clk_i,
  input  smf_pkg::smf_ctrl_t     ctrl_i,
  input  logic [CNT_W-1:0]       fill_i,
  input  logic [SAMPLE_BITS-1:0] val_i,
  input  logic [SAMPLE_BITS-1:0] probe_i,
  input  logic [IDX_W-1:0]       origin_i,
  output logic [SAMPLE_BITS-1:0] val_o,
  output logic [SAMPLE_BITS-1:0] probe_o,
  output logic [IDX_W-1:0]       origin_o,
  output logic                   hit_o
);
  import smf_pkg::*;

  logic [SAMPLE_BITS-1:0] val_q;
  logic [SAMPLE_BITS-1:0] probe_q;
  logic [IDX_W-1:0]       origin_q;
  logic [CNT_W-1:0]       rank_q;
  logic                   cell_valid;
  logic                   probe_valid;
  logic                   probe_below;

  assign cell_valid  = CNT_W'(CELL_IDX) < fill_i;
  assign probe_valid = CNT_W'(origin_q) < fill_i;
  // Equal samples are ordered by cell position so that every rank is unique.
  assign probe_below = (probe_q < val_q) ||
                       ((probe_q == val_q) && (origin_q < IDX_W'(CELL_IDX)));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      val_q    <= val_i;
      probe_q  <= val_i;
      origin_q <= IDX_W'(CELL_IDX);
      rank_q   <= '0;
    end else if (ctrl_i.rank_en) begin
      probe_q  <= probe_i;
      origin_q <= origin_i;
      if (probe_valid && probe_below) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  assign val_o    = val_q;
  assign probe_o  = probe_q;
  assign origin_o = origin_q;
  assign hit_o    = cell_valid && (rank_q == (fill_i >> 1));

endmodule

>>> src/smf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the median filter: accept, rank sweep and result hand-off.
module smf_ctrl #(
  parameter int unsigned WINDOW_SIZE = 31,
  parameter int unsigned STEP_W      = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  output logic               in_stall_o,
  output smf_pkg::smf_ctrl_t ctrl_o
);
  import smf_pkg::*;

  smf_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic              last_step;

  assign last_step = (step_q == STEP_W'(WINDOW_SIZE - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      SMF_IDLE: begin
        if (in_valid_i) begin
          state_d = SMF_RANK;
        end
      end
      SMF_RANK: begin
        if (last_step) begin
          state_d = SMF_PICK;
        end
      end
      SMF_PICK: begin
        if (out_free_i) begin
          state_d = SMF_IDLE;
        end
      end
      default: state_d = SMF_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      SMF_IDLE: begin
        in_stall_o  = 1'b0;
        ctrl_o.load = in_valid_i;
      end
      SMF_RANK: begin
        ctrl_o.rank_en = 1'b1;
      end
      SMF_PICK: begin
        ctrl_o.pick = out_free_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SMF_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl_o.load) begin
        step_q <= '0;
      end else if (ctrl_o.rank_en) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

endmodule

>>> src/sliding_window_median_filter.sv
`timescale 1ns / 1ps
// Top level of the sliding-window median filter.
// Each accepted item carries one converter sample, which enters a row of WINDOW_SIZE cells
// that hold the most recent samples, the oldest dropping off the far end once the row is
// full. For every sample the block returns one item with the median of the samples held so
// far (the upper median when the count is even) and the number of samples held. The median
// is found by ranking: every cell's sample is copied into a probe that circulates around
// the row one cell per cycle, and each cell counts how many held probes sort below its own
// sample, equal values being ordered by cell position. After one full lap the cell whose
// rank equals half the fill count holds the median. Each item is accepted, ranked in one lap
// of the probe ring, and loaded into the output register once that register is free. The
// output register lets the next sample be accepted while a result is still waiting to be
// taken. No clearing is needed after reset, since only cells below the fill count take
// part.
module sliding_window_median_filter #(
  parameter int unsigned WINDOW_SIZE = 31,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [SAMPLE_BITS-1:0]              sample_mv_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [SAMPLE_BITS-1:0]              median_mv_o,
  output logic [smf_pkg::COUNT_BITS-1:0]      held_count_o
);
  import smf_pkg::*;

  // Cell positions need IDX_W bits; the fill count must also reach WINDOW_SIZE itself.
  localparam int unsigned IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);

  smf_ctrl_t              ctrl;
  logic                   out_free;
  logic [CNT_W-1:0]       fill_q;
  logic [31:0]            fill_ext;

  logic [SAMPLE_BITS-1:0] val   [WINDOW_SIZE];
  logic [SAMPLE_BITS-1:0] probe [WINDOW_SIZE];
  logic [IDX_W-1:0]       origin[WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] hit;

  logic [SAMPLE_BITS-1:0] median_d;
  logic [SAMPLE_BITS-1:0] median_q;
  logic [COUNT_BITS-1:0]  held_q;
  logic                   out_valid_q;

  // The output register is free when it is empty or its item is taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  smf_ctrl #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .STEP_W     (IDX_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .out_free_i(out_free),
    .in_stall_o(in_stall_o),
    .ctrl_o    (ctrl)
  );

  // The fill count saturates at the window size; cells below it hold valid samples.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl.load && (fill_q < CNT_W'(WINDOW_SIZE))) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  // Samples shift from cell 0 toward the far end; probes run around the row as a ring.
  for (genvar gi = 0; gi < WINDOW_SIZE; gi++) begin : g_cell
    logic [SAMPLE_BITS-1:0] val_in;
    logic [SAMPLE_BITS-1:0] probe_in;
    logic [IDX_W-1:0]       origin_in;

    if (gi == 0) begin : g_head
      assign val_in    = sample_mv_i;
      assign probe_in  = probe[WINDOW_SIZE-1];
      assign origin_in = origin[WINDOW_SIZE-1];
    end else begin : g_body
      assign val_in    = val[gi-1];
      assign probe_in  = probe[gi-1];
      assign origin_in = origin[gi-1];
    end

    smf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .CELL_IDX   (gi)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .fill_i  (fill_q),
      .val_i   (val_in),
      .probe_i (probe_in),
      .origin_i(origin_in),
      .val_o   (val[gi]),
      .probe_o (probe[gi]),
      .origin_o(origin[gi]),
      .hit_o   (hit[gi])
    );
  end

  // Ranks are unique, so exactly one cell reports a hit and an OR collects its sample.
  always_comb begin
    median_d = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      median_d = median_d | (hit[i] ? val[i] : '0);
    end
  end

  // The reported count keeps only the low bits of the fill count.
  assign fill_ext = 32'(fill_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.pick) begin
      median_q <= median_d;
      held_q   <= fill_ext[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.pick) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign median_mv_o  = median_q;
  assign held_count_o = held_q;

`ifndef SYNTH
  // After a sample is accepted the block is busy ranking it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again right after a sample");

  // The fill count never passes the window size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW_SIZE))
    else $error("fill count beyond window size");

  // When the median is taken, exactly one cell holds the middle rank.
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pick |-> $onehot(hit))
    else $error("median rank not held by exactly one cell");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !ctrl.pick)
    else $error("pending result overwritten");
`endif

endmodule
